@@ hdl/ccb_pkg.sv @@
// Package for the cancel completion barrier.
// Holds the item structs, the function, status, barrier and detail codes, and the
// controller types. It depends on nothing else.
`default_nettype none

package ccb_pkg;

  // Function codes carried by an input item.
  localparam logic [1:0] FUNC_BEGIN_ROUND = 2'd0;
  localparam logic [1:0] FUNC_START_RESP  = 2'd1;
  localparam logic [1:0] FUNC_ADD_ID      = 2'd2;
  localparam logic [1:0] FUNC_OBSERVE     = 2'd3;

  // Reported goal states. The fourth code counts as terminal.
  localparam logic [1:0] GOAL_UNKNOWN  = 2'd0;
  localparam logic [1:0] GOAL_ACTIVE   = 2'd1;
  localparam logic [1:0] GOAL_TERMINAL = 2'd2;

  // Barrier states.
  localparam logic [1:0] BAR_WAITING = 2'd0;
  localparam logic [1:0] BAR_UNSAFE  = 2'd1;
  localparam logic [1:0] BAR_IDLE    = 2'd2;

  // Detail codes.
  localparam logic [2:0] DET_NO_RESP    = 3'd0;
  localparam logic [2:0] DET_NONE_NAMED = 3'd1;
  localparam logic [2:0] DET_WAITING    = 3'd2;
  localparam logic [2:0] DET_UNKNOWN    = 3'd3;
  localparam logic [2:0] DET_UNEXP_ACT  = 3'd4;
  localparam logic [2:0] DET_REGRESSED  = 3'd5;
  localparam logic [2:0] DET_ALL_TERM   = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] goal_id;
    logic [1:0]  status_state;
  } in_item_t;

  typedef struct packed {
    logic [1:0] barrier_state;
    logic [2:0] detail_code;
    logic       dropped;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } ccb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
  } ccb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ccb_stat_t;

endpackage

`default_nettype wire

@@ hdl/ccb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module ccb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/ccb_datapath.sv @@
// Datapath of the cancel completion barrier: identifier table, marks, counters,
// sequential search and output register. Uses ccb_pkg and ccb_ram.
`default_nettype none

module ccb_datapath
  import ccb_pkg::*;
#(
  parameter int MAX_GOALS = 16,
  parameter int ID_BITS   = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire ccb_cmd_t  cmd,
  output ccb_stat_t      stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int IDX_W = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
  localparam int CNT_W = $clog2(MAX_GOALS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GOALS);

  // Captured item.
  logic [1:0]         func_r;
  logic [ID_BITS-1:0] id_r;
  logic [1:0]         st_r;

  // Barrier state.
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   term_r, term_nxt;
  logic               resp_r, resp_nxt;
  logic               unsafe_r, unsafe_nxt;
  logic [2:0]         detail_r, detail_nxt;
  logic [MAX_GOALS-1:0] marks_r, marks_nxt;

  // Search state.
  logic [CNT_W-1:0]   idx_r;
  logic               pend_r;
  logic [IDX_W-1:0]   pidx_r;
  logic               found_r;
  logic [IDX_W-1:0]   slot_r;
  logic               match;

  // Output register.
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  // Table write enable and read data.
  logic               we;
  logic [ID_BITS-1:0] rdata;

  ccb_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MAX_GOALS)
  ) u_ids (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (id_r),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // The read data belongs to the entry issued in the previous cycle.
  assign match = pend_r && (rdata == id_r);

  assign stat.scan_done = found_r || (!pend_r && (idx_r >= count_r));
  assign stat.out_free  = !out_valid_r || out_ready;

  // Capture the item payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      id_r   <= in_data.goal_id[ID_BITS-1:0];
      st_r   <= in_data.status_state;
    end
  end

  // Sequential search over the held entries, one read issued per cycle during scan steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.load) begin
      idx_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_step && !found_r) begin
      if (match) begin
        found_r <= 1'b1;
        slot_r  <= pidx_r;
        pend_r  <= 1'b0;
      end else if (idx_r < count_r) begin
        idx_r  <= idx_r + CNT_W'(1);
        pidx_r <= idx_r[IDX_W-1:0];
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  // Effect of the captured item on the barrier state.
  always_comb begin
    count_nxt  = count_r;
    term_nxt   = term_r;
    resp_nxt   = resp_r;
    unsafe_nxt = unsafe_r;
    detail_nxt = detail_r;
    marks_nxt  = marks_r;
    we         = 1'b0;
    out_nxt.dropped = 1'b0;
    case (func_r)
      FUNC_BEGIN_ROUND, FUNC_START_RESP: begin
        count_nxt  = '0;
        term_nxt   = '0;
        marks_nxt  = '0;
        unsafe_nxt = 1'b0;
        resp_nxt   = (func_r == FUNC_START_RESP);
        detail_nxt = (func_r == FUNC_START_RESP) ? DET_NONE_NAMED : DET_NO_RESP;
      end
      FUNC_ADD_ID: begin
        if (resp_r && !unsafe_r) begin
          if (!found_r) begin
            if (count_r < CNT_MAX) begin
              we = cmd.apply;
              marks_nxt[count_r[IDX_W-1:0]] = 1'b0;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              out_nxt.dropped = 1'b1;
            end
          end
          detail_nxt = (count_nxt != '0 && term_r == count_nxt) ? DET_ALL_TERM
                                                                : DET_WAITING;
        end
      end
      default: begin
        if (resp_r && !unsafe_r) begin
          case (st_r)
            GOAL_UNKNOWN: begin
              unsafe_nxt = 1'b1;
              detail_nxt = DET_UNKNOWN;
            end
            GOAL_ACTIVE: begin
              if (!found_r) begin
                unsafe_nxt = 1'b1;
                detail_nxt = DET_UNEXP_ACT;
              end else if (marks_r[slot_r]) begin
                unsafe_nxt = 1'b1;
                detail_nxt = DET_REGRESSED;
              end
            end
            default: begin
              if (found_r && !marks_r[slot_r]) begin
                marks_nxt[slot_r] = 1'b1;
                term_nxt = term_r + CNT_W'(1);
              end
            end
          endcase
          if (!unsafe_nxt && count_r != '0 && term_nxt == count_r) begin
            detail_nxt = DET_ALL_TERM;
          end
        end
      end
    endcase
    // Barrier state as seen after the item.
    if (!resp_nxt) begin
      out_nxt.barrier_state = BAR_WAITING;
    end else if (unsafe_nxt) begin
      out_nxt.barrier_state = BAR_UNSAFE;
    end else if (count_nxt == '0 || term_nxt == count_nxt) begin
      out_nxt.barrier_state = BAR_IDLE;
    end else begin
      out_nxt.barrier_state = BAR_WAITING;
    end
    out_nxt.detail_code = detail_nxt;
  end

  // Commit the item and load the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      term_r      <= '0;
      resp_r      <= 1'b0;
      unsafe_r    <= 1'b0;
      detail_r    <= DET_NO_RESP;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        count_r     <= count_nxt;
        term_r      <= term_nxt;
        resp_r      <= resp_nxt;
        unsafe_r    <= unsafe_nxt;
        detail_r    <= detail_nxt;
        marks_r     <= marks_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ hdl/ccb_ctrl.sv @@
// Controller state machine of the cancel completion barrier.
// Uses ccb_pkg; drives the datapath through command and status structs.
`default_nettype none

module ccb_ctrl
  import ccb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ccb_stat_t stat,
  output ccb_cmd_t       cmd
);

  ccb_state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.apply     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:  cmd.scan_step = 1'b1;
      ST_APPLY: cmd.apply = stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cancel_completion_barrier.sv @@
// Cancel completion barrier: each item opens a round, starts a cancel response,
// adds an identifier or reports a goal status, and gives one result with the
// barrier state, a detail code and a dropped flag. The search for the item's
// identifier reads the identifier table, one entry a cycle through its single
// registered read port, and stops at the first match. A new item is taken
// while the previous result still waits at the output register; it is committed
// once that result has gone. Identifiers are compared on their low ID_BITS bits.
// Uses ccb_pkg, ccb_ctrl and ccb_datapath.
`default_nettype none

module cancel_completion_barrier
  import ccb_pkg::*;
#(
  parameter int MAX_GOALS = 16,
  parameter int ID_BITS   = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  ccb_cmd_t  cmd;
  ccb_stat_t stat;

  ccb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ccb_datapath #(
    .MAX_GOALS (MAX_GOALS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
